[sv/adsf_pkg.sv]
`timescale 1ns / 1ps

package adsf_pkg;

   localparam int NAME_MAX_LEN_DEF = 29;
   localparam int SSID_MAX_LEN_DEF = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [7:0] TYPE_UUID16_SOME   = 8'h02;
   localparam logic [7:0] TYPE_UUID16_ALL    = 8'h03;
   localparam logic [7:0] TYPE_NAME_SHORT    = 8'h08;
   localparam logic [7:0] TYPE_NAME_COMPLETE = 8'h09;
   localparam logic [7:0] TYPE_MANUFACTURER  = 8'hFF;

   localparam logic [15:0] SERVICE_UUID_RST = 16'h1820;
   localparam logic [15:0] COMPANY_ID_RST   = 16'h0059;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REQUIRE_SSID    = 3'd0,
      CSR_SSID_LENGTH     = 3'd1,
      CSR_SSID_BYTES_LOW  = 3'd2,
      CSR_SSID_BYTES_HIGH = 3'd3,
      CSR_SERVICE_UUID    = 3'd4,
      CSR_COMPANY_ID      = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_LENGTH  = 2'd0,
      PH_TYPE    = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef struct packed {
      logic        require_ssid;
      logic [4:0]  ssid_length;
      logic [63:0] ssid_bytes_low;
      logic [63:0] ssid_bytes_high;
      logic [15:0] service_uuid;
      logic [15:0] company_id;
   } cfg_type;

   function automatic logic is_uuid_list(input logic [7:0] t);
      return (t == TYPE_UUID16_SOME) || (t == TYPE_UUID16_ALL);
   endfunction

   function automatic logic is_name(input logic [7:0] t);
      return (t == TYPE_NAME_SHORT) || (t == TYPE_NAME_COMPLETE);
   endfunction

endpackage

[sv/adsf_req_if.sv]
`timescale 1ns / 1ps

interface adsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ad_byte;
   logic       last_byte;

   modport source (output valid, output ad_byte, output last_byte, input ready);
   modport sink (input valid, input ad_byte, input last_byte, output ready);
endinterface

[sv/adsf_rsp_if.sv]
`timescale 1ns / 1ps

interface adsf_rsp_if;
   logic       valid;
   logic       ready;
   logic       name_valid;
   logic [7:0] name_byte;
   logic       report_done;
   logic       service_match;

   modport source (output valid, output name_valid, output name_byte,
                   output report_done, output service_match, input ready);
   modport sink (input valid, input name_valid, input name_byte,
                 input report_done, input service_match, output ready);
endinterface

[sv/advertising_data_service_filter_top.sv]
`timescale 1ns / 1ps

// Advertising data filter.
// The req channel carries one advertising data byte per word, with
// last_byte marking the final byte of a report. The rsp channel returns
// exactly one word per accepted req word: name_valid/name_byte pass out
// the bytes of a name structure that fits, and on the word for the last
// byte report_done is set with service_match telling whether the device
// qualifies (service UUID seen, and the SSID manufacturer structure seen
// when require_ssid is set).
// The result word is registered the cycle after its byte is accepted.
// Throughput is one byte per cycle while the receiver takes each result,
// bounded by the update of the parse state from each byte.
// When the receiver stalls, the result stays in the output register and
// req stays ready only if that result is taken in the same cycle.
// Synchronous reset clears the parse state and the output valid flag and
// loads the csr defaults; csr writes take effect at once, so they belong
// in idle periods with no word in flight.
module advertising_data_service_filter_top
   import adsf_pkg::*;
#(
   parameter int NAME_MAX_LEN = NAME_MAX_LEN_DEF,
   parameter int SSID_MAX_LEN = SSID_MAX_LEN_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   adsf_req_if.sink               req_chan,
   adsf_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;

   adsf_csr u_csr (
      .clock (clock),
      .reset (reset),
      .we    (csr_we),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   adsf_parser #(
      .NAME_MAX_LEN (NAME_MAX_LEN),
      .SSID_MAX_LEN (SSID_MAX_LEN)
   ) u_parser (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .in_valid          (req_chan.valid),
      .in_ready          (req_chan.ready),
      .in_ad_byte        (req_chan.ad_byte),
      .in_last_byte      (req_chan.last_byte),
      .out_valid         (rsp_chan.valid),
      .out_ready         (rsp_chan.ready),
      .out_name_valid    (rsp_chan.name_valid),
      .out_name_byte     (rsp_chan.name_byte),
      .out_report_done   (rsp_chan.report_done),
      .out_service_match (rsp_chan.service_match)
   );

endmodule

[sv/adsf_csr.sv]
`timescale 1ns / 1ps

module adsf_csr
   import adsf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   we,
   input  logic [CSR_INDEX_W-1:0] index,
   input  logic [CSR_DATA_W-1:0]  wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.require_ssid    <= 1'b0;
         cfg_ff.ssid_length     <= 5'd0;
         cfg_ff.ssid_bytes_low  <= 64'd0;
         cfg_ff.ssid_bytes_high <= 64'd0;
         cfg_ff.service_uuid    <= SERVICE_UUID_RST;
         cfg_ff.company_id      <= COMPANY_ID_RST;
      end else if (we) begin
         case (csr_index_type'(index))
            CSR_REQUIRE_SSID:    cfg_ff.require_ssid    <= wdata[0];
            CSR_SSID_LENGTH:     cfg_ff.ssid_length     <= wdata[4:0];
            CSR_SSID_BYTES_LOW:  cfg_ff.ssid_bytes_low  <= wdata;
            CSR_SSID_BYTES_HIGH: cfg_ff.ssid_bytes_high <= wdata;
            CSR_SERVICE_UUID:    cfg_ff.service_uuid    <= wdata[15:0];
            CSR_COMPANY_ID:      cfg_ff.company_id      <= wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/adsf_parser.sv]
`timescale 1ns / 1ps

module adsf_parser
   import adsf_pkg::*;
#(
   parameter int NAME_MAX_LEN = NAME_MAX_LEN_DEF,
   parameter int SSID_MAX_LEN = SSID_MAX_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_ad_byte,
   input  logic       in_last_byte,
   output logic       out_valid,
   input  logic       out_ready,
   output logic       out_name_valid,
   output logic [7:0] out_name_byte,
   output logic       out_report_done,
   output logic       out_service_match
);

   phase_type  phase_ff, phase_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] pend_ff, pend_in;
   logic       svc_ff, svc_in;
   logic       ssid_ff, ssid_in;
   logic       eq_ff, eq_in;
   logic       copy_ff, copy_in;

   logic       out_valid_ff;
   logic       name_valid_ff;
   logic [7:0] name_byte_ff;
   logic       done_ff;
   logic       match_ff;

   logic       accept;
   logic       finish;
   logic       nvalid;
   logic       match;
   logic [4:0] ssid_n;
   logic [7:0] pos_m2;
   logic       byte_ok;
   logic [15:0][7:0] ssid_bytes;

   assign in_ready   = !out_valid_ff || out_ready;
   assign accept     = in_valid && in_ready;
   assign ssid_bytes = {cfg.ssid_bytes_high, cfg.ssid_bytes_low};
   assign ssid_n     = (cfg.ssid_length > 5'(SSID_MAX_LEN)) ? 5'(SSID_MAX_LEN)
                                                           : cfg.ssid_length;
   assign pos_m2     = pos_ff - 8'd2;

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      type_in  = type_ff;
      pos_in   = pos_ff;
      pend_in  = pend_ff;
      svc_in   = svc_ff;
      ssid_in  = ssid_ff;
      eq_in    = eq_ff;
      copy_in  = copy_ff;
      finish   = 1'b0;
      nvalid   = 1'b0;
      match    = 1'b0;
      byte_ok  = 1'b0;

      case (phase_ff)
         PH_TYPE: begin
            type_in = in_ad_byte;
            pos_in  = 8'd0;
            pend_in = 8'd0;
            eq_in   = (in_ad_byte == TYPE_MANUFACTURER);
            copy_in = is_name(in_ad_byte) && ((len_ff - 8'd1) <= 8'(NAME_MAX_LEN));
            if (len_ff == 8'd1) begin
               finish = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (is_uuid_list(type_ff)) begin
               if (!pos_ff[0]) begin
                  pend_in = in_ad_byte;
               end else if ({in_ad_byte, pend_ff} == cfg.service_uuid) begin
                  eq_in = 1'b1;
               end
            end else if (type_ff == TYPE_MANUFACTURER) begin
               if (pos_ff == 8'd0) begin
                  byte_ok = (in_ad_byte == cfg.company_id[7:0]);
               end else if (pos_ff == 8'd1) begin
                  byte_ok = (in_ad_byte == cfg.company_id[15:8]);
               end else if (pos_m2 < {3'd0, ssid_n}) begin
                  byte_ok = (in_ad_byte == ssid_bytes[pos_m2[3:0]]);
               end
               if (!byte_ok) begin
                  eq_in = 1'b0;
               end
            end else if (copy_ff) begin
               nvalid = 1'b1;
            end
            pos_in = pos_ff + 8'd1;
            if (({1'b0, pos_ff} + 9'd1) == ({1'b0, len_ff} - 9'd1)) begin
               finish = 1'b1;
            end
         end
         default: begin
            if (in_ad_byte != 8'd0) begin
               len_in   = in_ad_byte;
               phase_in = PH_TYPE;
            end else begin
               phase_in = PH_LENGTH;
            end
         end
      endcase

      if (finish) begin
         if (is_uuid_list(type_in) && eq_in) begin
            svc_in = 1'b1;
         end
         if ((type_in == TYPE_MANUFACTURER) && eq_in &&
             ((len_ff - 8'd1) == ({3'd0, ssid_n} + 8'd2))) begin
            ssid_in = 1'b1;
         end
         phase_in = PH_LENGTH;
         eq_in    = 1'b0;
         copy_in  = 1'b0;
      end

      if (in_last_byte) begin
         match    = svc_in && (ssid_in || !cfg.require_ssid);
         phase_in = PH_LENGTH;
         len_in   = 8'd0;
         type_in  = 8'd0;
         pos_in   = 8'd0;
         pend_in  = 8'd0;
         eq_in    = 1'b0;
         copy_in  = 1'b0;
         svc_in   = 1'b0;
         ssid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LENGTH;
         len_ff   <= 8'd0;
         type_ff  <= 8'd0;
         pos_ff   <= 8'd0;
         pend_ff  <= 8'd0;
         svc_ff   <= 1'b0;
         ssid_ff  <= 1'b0;
         eq_ff    <= 1'b0;
         copy_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         type_ff  <= type_in;
         pos_ff   <= pos_in;
         pend_ff  <= pend_in;
         svc_ff   <= svc_in;
         ssid_ff  <= ssid_in;
         eq_ff    <= eq_in;
         copy_ff  <= copy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         name_valid_ff <= nvalid;
         name_byte_ff  <= nvalid ? in_ad_byte : 8'd0;
         done_ff       <= in_last_byte;
         match_ff      <= match;
      end
   end

   assign out_valid         = out_valid_ff;
   assign out_name_valid    = name_valid_ff;
   assign out_name_byte     = name_byte_ff;
   assign out_report_done   = done_ff;
   assign out_service_match = match_ff;

   // every accepted word shows up as a result in the next cycle
   assert property (@(posedge clock) disable iff (reset) accept |=> out_valid_ff)
      else $error("accepted word produced no result");

   // end of report clears all parse and report state
   assert property (@(posedge clock) disable iff (reset)
      (accept && in_last_byte) |=>
         (phase_ff == PH_LENGTH) && !svc_ff && !ssid_ff && !eq_ff && !copy_ff)
      else $error("parse state not cleared after last byte");

   // match flag only rides on the final result of a report
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !done_ff) |-> !match_ff)
      else $error("service match outside report end");

   // name bytes never come out of a structure that was not a name structure
   assert property (@(posedge clock) disable iff (reset)
      (accept && nvalid) |-> (phase_ff == PH_PAYLOAD) && is_name(type_ff))
      else $error("name byte outside a name structure");

endmodule
